// ----- sv/cfse_pkg.sv -----
// ============================================================================
// Clock field set editor package
// Command codes, field indexes, field bounds, display places and the
// wrap-around step used by the clock field set editor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cfse_pkg;

    // Command codes carried on s_tuser.
    localparam logic [2:0] FUNC_LOAD   = 3'd0;
    localparam logic [2:0] FUNC_HOME   = 3'd1;
    localparam logic [2:0] FUNC_NEXT   = 3'd2;
    localparam logic [2:0] FUNC_PREV   = 3'd3;
    localparam logic [2:0] FUNC_INCR   = 3'd4;
    localparam logic [2:0] FUNC_DECR   = 3'd5;

    // Field indexes, in cursor order.
    localparam logic [2:0] FIELD_WEEKDAY = 3'd0;
    localparam logic [2:0] FIELD_MON     = 3'd1;
    localparam logic [2:0] FIELD_MDAY    = 3'd2;
    localparam logic [2:0] FIELD_YR      = 3'd3;
    localparam logic [2:0] FIELD_HOURS   = 3'd4;
    localparam logic [2:0] FIELD_MINUTES = 3'd5;
    localparam logic [2:0] FIELD_SECONDS = 3'd6;
    localparam logic [2:0] FIELD_PM      = 3'd7;

    // Stream widths.
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 48;

    // The clock fields (weekday, month, date, year, hours, minutes, seconds, pm) at their stored widths.
    typedef struct packed {
        logic [2:0] weekday;
        logic [3:0] month;
        logic [4:0] date;
        logic [6:0] year;
        logic [3:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       pm;
    } clock_fields_t;

    // Lowest legal value of a field.
    function automatic logic [7:0] field_low(input logic [2:0] idx);
        logic [7:0] lo;
        unique case (idx)
            FIELD_WEEKDAY, FIELD_MON, FIELD_MDAY, FIELD_HOURS: lo = 8'd1;
            default:                                           lo = 8'd0;
        endcase
        return lo;
    endfunction

    // Highest legal value of a field.
    function automatic logic [7:0] field_high(input logic [2:0] idx);
        logic [7:0] hi;
        unique case (idx)
            FIELD_WEEKDAY: hi = 8'd7;
            FIELD_MON:     hi = 8'd12;
            FIELD_MDAY:    hi = 8'd31;
            FIELD_YR:      hi = 8'd99;
            FIELD_HOURS:   hi = 8'd12;
            FIELD_MINUTES: hi = 8'd59;
            FIELD_SECONDS: hi = 8'd59;
            default:       hi = 8'd1;
        endcase
        return hi;
    endfunction

    // Display column of a field; the row is the upper bit of the index.
    function automatic logic [3:0] field_column(input logic [2:0] idx);
        logic [3:0] col;
        unique case (idx)
            FIELD_WEEKDAY: col = 4'd0;
            FIELD_MON:     col = 4'd5;
            FIELD_MDAY:    col = 4'd8;
            FIELD_YR:      col = 4'd13;
            FIELD_HOURS:   col = 4'd1;
            FIELD_MINUTES: col = 4'd4;
            FIELD_SECONDS: col = 4'd7;
            default:       col = 4'd9;
        endcase
        return col;
    endfunction

    // Step a value by one in either direction, wrapping to the far bound
    // when the result leaves the legal range.
    function automatic logic [7:0] step_value(
        input logic [7:0] old,
        input logic [7:0] lo,
        input logic [7:0] hi,
        input logic       down
    );
        logic [7:0] up;
        logic [7:0] dn;
        logic [7:0] res;
        up = old + 8'd1;
        dn = old - 8'd1;
        if (down) begin
            // A value at or below the low bound would drop under it.
            if (old <= lo)
                res = hi;
            else if (dn > hi)
                res = lo;
            else
                res = dn;
        end else begin
            if (up < lo)
                res = hi;
            else if (up > hi)
                res = lo;
            else
                res = up;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/clock_field_set_editor_core.sv -----
// ============================================================================
// Clock field set editor core
// Holds the clock fields and a field cursor; each input beat loads the
// fields, moves the cursor, steps the selected field or, for an unused
// code, changes nothing, and each produces one result beat with all fields and the cursor's display place.
// ============================================================================
// Result: the result beat of an accepted input beat is registered and valid in the cycle after.
// Throughput: one beat per cycle; the single output register takes a new
// result whenever it is empty or being drained in the same cycle.
// Reset: fields go to Sunday, January 1, year 0, 12:00:00 AM, the cursor
// goes to the weekday field, and the output register is emptied.
`timescale 1ns / 1ps
`default_nettype none

module clock_field_set_editor_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // load_weekday, load_month, load_date, load_year, load_hours,
    // load_minutes, load_seconds, load_pm, zero fill (bit 0 up)
    input  wire logic [cfse_pkg::S_DATA_W-1:0] s_tdata,
    // func
    input  wire logic [cfse_pkg::S_USER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // weekday, month, date, year, hours, minutes, seconds, pm,
    // cursor_field, cursor_row, cursor_column, zero fill (bit 0 up)
    output logic [cfse_pkg::M_DATA_W-1:0]      m_tdata
);

    cfse_pkg::clock_fields_t fields_reg;
    cfse_pkg::clock_fields_t fields_next;
    cfse_pkg::clock_fields_t load_fields;
    logic [2:0]              cursor_reg;
    logic [2:0]              cursor_next;
    logic                    out_valid_reg;
    logic [cfse_pkg::M_DATA_W-1:0] out_data_reg;
    logic [cfse_pkg::M_DATA_W-1:0] out_data_next;
    logic                    accept;
    logic [6:0]              sel_old;
    logic [7:0]              stepped;

    // The output register frees up when empty or drained this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Unpack the load values from the input beat.
    assign load_fields.weekday = s_tdata[2:0];
    assign load_fields.month   = s_tdata[6:3];
    assign load_fields.date    = s_tdata[11:7];
    assign load_fields.year    = s_tdata[18:12];
    assign load_fields.hours   = s_tdata[22:19];
    assign load_fields.minutes = s_tdata[28:23];
    assign load_fields.seconds = s_tdata[34:29];
    assign load_fields.pm      = s_tdata[35];

    // Select the field under the cursor.
    always_comb
    begin
        unique case (cursor_reg)
            cfse_pkg::FIELD_WEEKDAY: sel_old = {4'd0, fields_reg.weekday};
            cfse_pkg::FIELD_MON:     sel_old = {3'd0, fields_reg.month};
            cfse_pkg::FIELD_MDAY:    sel_old = {2'd0, fields_reg.date};
            cfse_pkg::FIELD_YR:      sel_old = fields_reg.year;
            cfse_pkg::FIELD_HOURS:   sel_old = {3'd0, fields_reg.hours};
            cfse_pkg::FIELD_MINUTES: sel_old = {1'b0, fields_reg.minutes};
            cfse_pkg::FIELD_SECONDS: sel_old = {1'b0, fields_reg.seconds};
            default:                 sel_old = {6'd0, fields_reg.pm};
        endcase
    end

    // Wrap-around step of the selected field.
    assign stepped = cfse_pkg::step_value({1'b0, sel_old},
                                          cfse_pkg::field_low(cursor_reg),
                                          cfse_pkg::field_high(cursor_reg),
                                          s_tuser == cfse_pkg::FUNC_DECR);

    // Command decode.
    always_comb
    begin
        fields_next = fields_reg;
        cursor_next = cursor_reg;
        unique case (s_tuser)
            cfse_pkg::FUNC_LOAD: fields_next = load_fields;
            cfse_pkg::FUNC_HOME: cursor_next = cfse_pkg::FIELD_WEEKDAY;
            cfse_pkg::FUNC_NEXT: cursor_next = cursor_reg + 3'd1;
            cfse_pkg::FUNC_PREV: cursor_next = cursor_reg - 3'd1;
            cfse_pkg::FUNC_INCR, cfse_pkg::FUNC_DECR:
            begin
                unique case (cursor_reg)
                    cfse_pkg::FIELD_WEEKDAY: fields_next.weekday = stepped[2:0];
                    cfse_pkg::FIELD_MON:     fields_next.month   = stepped[3:0];
                    cfse_pkg::FIELD_MDAY:    fields_next.date    = stepped[4:0];
                    cfse_pkg::FIELD_YR:      fields_next.year    = stepped[6:0];
                    cfse_pkg::FIELD_HOURS:   fields_next.hours   = stepped[3:0];
                    cfse_pkg::FIELD_MINUTES: fields_next.minutes = stepped[5:0];
                    cfse_pkg::FIELD_SECONDS: fields_next.seconds = stepped[5:0];
                    default:                 fields_next.pm      = stepped[0];
                endcase
            end
            default:
            begin
                fields_next = fields_reg;
                cursor_next = cursor_reg;
            end
        endcase
    end

    // Pack the result beat from the updated state.
    assign out_data_next = {4'd0,
                            cfse_pkg::field_column(cursor_next),
                            cursor_next[2],
                            cursor_next,
                            fields_next.pm,
                            fields_next.seconds,
                            fields_next.minutes,
                            fields_next.hours,
                            fields_next.year,
                            fields_next.date,
                            fields_next.month,
                            fields_next.weekday};

    // Clock field and cursor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fields_reg.weekday <= 3'd1;
            fields_reg.month   <= 4'd1;
            fields_reg.date    <= 5'd1;
            fields_reg.year    <= 7'd0;
            fields_reg.hours   <= 4'd12;
            fields_reg.minutes <= 6'd0;
            fields_reg.seconds <= 6'd0;
            fields_reg.pm      <= 1'b0;
            cursor_reg         <= cfse_pkg::FIELD_WEEKDAY;
        end else if (accept) begin
            fields_reg <= fields_next;
            cursor_reg <= cursor_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // An accepted beat always leaves a result waiting.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted beat produced no result");

    // Input stalls only behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    // Next-field command advances the cursor by one with wrap.
    a_cursor_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == cfse_pkg::FUNC_NEXT) |=>
            cursor_reg == $past(cursor_reg) + 3'd1)
        else $error("cursor did not advance");

    // The reported row and field index follow the cursor register.
    a_row_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39] == m_tdata[38] && m_tdata[38:36] == cursor_reg))
        else $error("reported cursor disagrees with state");

    // Field steps never leave a stepped month outside its bounds.
    a_month_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cursor_reg == cfse_pkg::FIELD_MON &&
         (s_tuser == cfse_pkg::FUNC_INCR || s_tuser == cfse_pkg::FUNC_DECR)) |=>
            (fields_reg.month >= 4'd1 && fields_reg.month <= 4'd12))
        else $error("stepped month out of range");

endmodule

`default_nettype wire
